@@ design/ohs_pkg.sv @@
// shared types, codes and defaults for the open-addressed hash set
`timescale 1ns / 1ps
`default_nettype none

package ohs_pkg;

	localparam int DEF_TABLE_SLOTS = 256;
	localparam int DEF_KEY_BITS    = 31;

	localparam int CNT_W       = 9;
	localparam int ACT_W       = 2;
	localparam int TAG_W       = 2;
	localparam int OUT_TDATA_W = 16;
	localparam int OUT_TUSER_W = 2;

	localparam logic [CNT_W-1:0] MAX_ENTRIES_RESET = 9'd171;

	localparam logic [ACT_W-1:0] ACT_ADD    = 2'd0;
	localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
	localparam logic [ACT_W-1:0] ACT_TEST   = 2'd2;

	typedef enum logic [TAG_W-1:0] {
		TAG_EMPTY = 2'd0,
		TAG_LIVE  = 2'd1,
		TAG_TOMB  = 2'd2
	} tag_t;

	typedef struct packed {
		logic clear_en;
		logic load;
		logic advance;
		logic commit;
	} ohs_cmd_t;

	typedef struct packed {
		logic clear_done;
		logic probe_end;
		logic out_free;
	} ohs_sts_t;

endpackage

`default_nettype wire

@@ design/open_address_hash_set.sv @@
// top level of the open-addressed hash set with tombstones
//
//  channel   | signals                              | carries
//  ----------+--------------------------------------+------------------------------------
//  s_axis    | tvalid, tready, tdata, tuser         | request: action, key
//  m_axis    | tvalid, tready, tdata, tuser         | result: present, rejected, live_count
//  cfg       | valid, ready, data                   | max_entries write
//
// a request is taken in an intake step, then probes the slots on its chain one at a time,
// set by the single read port of the slot table (at most TABLE_SLOTS probes)
// after reset a clearing pass writes every slot empty
// with s_axis_tready low; cfg writes are taken throughout
// a finished result waits in the output register while the next request is taken;
// a request whose probe ends while that register is still full holds until it drains
// the table size must be a power of two: the home slot is the key's low bits
`timescale 1ns / 1ps
`default_nettype none

module open_address_hash_set #(
	parameter int TABLE_SLOTS = ohs_pkg::DEF_TABLE_SLOTS,
	parameter int KEY_BITS    = ohs_pkg::DEF_KEY_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [((KEY_BITS+7)/8)*8-1:0]        s_axis_tdata,   // key
	input  logic [ohs_pkg::ACT_W-1:0]            s_axis_tuser,   // action
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	output logic [ohs_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,   // live_count
	output logic [ohs_pkg::OUT_TUSER_W-1:0]      m_axis_tuser,   // present, rejected
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [ohs_pkg::CNT_W-1:0]            cfg_data        // max_entries
);

	import ohs_pkg::*;

	ohs_cmd_t         cmd;
	ohs_sts_t         sts;
	logic             present;
	logic             rejected;
	logic [CNT_W-1:0] live_count;

	assign cfg_ready = 1'b1;

	ohs_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.cmd     (cmd),
		.sts     (sts)
	);

	ohs_dp #(
		.TABLE_SLOTS(TABLE_SLOTS),
		.KEY_BITS   (KEY_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.in_action   (s_axis_tuser),
		.in_key      (s_axis_tdata[KEY_BITS-1:0]),
		.cfg_valid   (cfg_valid),
		.cfg_data    (cfg_data),
		.out_ready   (m_axis_tready),
		.out_valid   (m_axis_tvalid),
		.out_present (present),
		.out_rejected(rejected),
		.out_live    (live_count)
	);

	assign m_axis_tdata = OUT_TDATA_W'(live_count);
	assign m_axis_tuser = {rejected, present};

	a_no_intake_while_clearing : assert property (
		@(posedge clk) disable iff (!arst_n) cmd.clear_en |-> !s_axis_tready
	) else $error("request taken during clearing pass");

	a_commit_needs_room : assert property (
		@(posedge clk) disable iff (!arst_n) cmd.commit |-> sts.out_free
	) else $error("result overwrote a waiting result");

	a_reject_means_absent : assert property (
		@(posedge clk) disable iff (!arst_n) m_axis_tvalid |-> !(present && rejected)
	) else $error("rejected add reported a present key");

	a_one_step_at_a_time : assert property (
		@(posedge clk) disable iff (!arst_n) $onehot0({cmd.clear_en, cmd.load, cmd.advance, cmd.commit})
	) else $error("conflicting datapath commands");

endmodule

`default_nettype wire

@@ design/ohs_ram.sv @@
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module ohs_ram #(
	parameter int WIDTH = 33,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

@@ design/ohs_ctrl.sv @@
// controller state machine: clearing sweep, request intake and probe sequencing
`timescale 1ns / 1ps
`default_nettype none

module ohs_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output ohs_pkg::ohs_cmd_t cmd,
	input  ohs_pkg::ohs_sts_t sts
);

	import ohs_pkg::*;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PROBE
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear_en = 1'b1;
			end
			ST_IDLE: begin
				cmd.load = in_valid;
			end
			ST_PROBE: begin
				cmd.advance = !sts.probe_end;
				cmd.commit  = sts.probe_end && sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					if (sts.clear_done) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_PROBE;
					end
				end
				ST_PROBE: begin
					if (sts.probe_end && sts.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

@@ design/ohs_dp.sv @@
// datapath: slot table, probe registers, live count, limit register and result register
`timescale 1ns / 1ps
`default_nettype none

module ohs_dp #(
	parameter int TABLE_SLOTS = ohs_pkg::DEF_TABLE_SLOTS,
	parameter int KEY_BITS    = ohs_pkg::DEF_KEY_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ohs_pkg::ohs_cmd_t           cmd,
	output ohs_pkg::ohs_sts_t           sts,
	input  logic [ohs_pkg::ACT_W-1:0]   in_action,
	input  logic [KEY_BITS-1:0]         in_key,
	input  logic                        cfg_valid,
	input  logic [ohs_pkg::CNT_W-1:0]   cfg_data,
	input  logic                        out_ready,
	output logic                        out_valid,
	output logic                        out_present,
	output logic                        out_rejected,
	output logic [ohs_pkg::CNT_W-1:0]   out_live
);

	import ohs_pkg::*;

	localparam int SLOT_BITS = $clog2(TABLE_SLOTS);
	localparam int ENTRY_W   = KEY_BITS + TAG_W;
	localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(TABLE_SLOTS - 1);

	logic [ACT_W-1:0]     action_q;
	logic [KEY_BITS-1:0]  key_q;
	logic [SLOT_BITS-1:0] slot_q;
	logic [SLOT_BITS-1:0] n_q;
	logic [SLOT_BITS-1:0] free_q;
	logic                 has_free_q;
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     max_q;

	logic                 out_valid_q;
	logic                 present_q;
	logic                 rejected_q;
	logic [CNT_W-1:0]     live_q;

	logic [SLOT_BITS-1:0] home;
	logic [SLOT_BITS-1:0] next_slot;
	logic [SLOT_BITS-1:0] raddr;
	logic [SLOT_BITS-1:0] waddr;
	logic [ENTRY_W-1:0]   wdata;
	logic                 we;
	logic [ENTRY_W-1:0]   rdata;

	tag_t                 rd_tag;
	logic [KEY_BITS-1:0]  rd_key;
	logic                 is_live;
	logic                 is_empty;
	logic                 match;
	logic                 last;
	logic [SLOT_BITS-1:0] free_now;
	logic                 hf_now;
	logic                 upd_we;
	logic [SLOT_BITS-1:0] upd_slot;
	tag_t                 upd_tag;
	logic                 rej;
	logic [CNT_W-1:0]     count_nxt;

	assign home      = SLOT_BITS'(in_key);
	assign next_slot = (slot_q << 2) + slot_q + SLOT_BITS'(1);

	assign rd_tag   = tag_t'(rdata[TAG_W-1:0]);
	assign rd_key   = rdata[ENTRY_W-1:TAG_W];
	assign is_live  = (rd_tag == TAG_LIVE);
	assign is_empty = (rd_tag == TAG_EMPTY);
	assign match    = is_live && (rd_key == key_q);
	assign last     = (n_q == LAST_SLOT);
	assign hf_now   = has_free_q || !is_live;
	assign free_now = (!has_free_q && !is_live) ? slot_q : free_q;

	// table update and result for the request that ends its probe this cycle
	always_comb begin
		upd_we    = 1'b0;
		upd_slot  = slot_q;
		upd_tag   = TAG_LIVE;
		rej       = 1'b0;
		count_nxt = count_q;
		case (action_q)
			ACT_ADD: begin
				if (!match) begin
					if ((count_q >= max_q) || !hf_now) begin
						rej = 1'b1;
					end else begin
						upd_we    = 1'b1;
						upd_slot  = free_now;
						count_nxt = count_q + CNT_W'(1);
					end
				end
			end
			ACT_REMOVE: begin
				if (match) begin
					upd_we    = 1'b1;
					upd_tag   = TAG_TOMB;
					count_nxt = count_q - CNT_W'(1);
				end
			end
			default: begin
				upd_we = 1'b0;
			end
		endcase
	end

	always_comb begin
		if (cmd.load) begin
			raddr = home;
		end else if (cmd.advance) begin
			raddr = next_slot;
		end else begin
			raddr = slot_q;
		end
	end

	always_comb begin
		if (cmd.clear_en) begin
			we    = 1'b1;
			waddr = slot_q;
			wdata = '0;
		end else begin
			we    = cmd.commit && upd_we;
			waddr = upd_slot;
			wdata = {key_q, upd_tag};
		end
	end

	ohs_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_SLOTS)
	) u_table (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign sts.clear_done = cmd.clear_en && (slot_q == LAST_SLOT);
	assign sts.probe_end  = is_empty || match || last;
	assign sts.out_free   = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q  <= '0;
			count_q <= '0;
			max_q   <= MAX_ENTRIES_RESET;
		end else begin
			if (cmd.clear_en) begin
				slot_q <= slot_q + SLOT_BITS'(1);
			end else if (cmd.load) begin
				slot_q <= home;
			end else if (cmd.advance) begin
				slot_q <= next_slot;
			end
			if (cmd.commit) begin
				count_q <= count_nxt;
			end
			if (cfg_valid) begin
				max_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q   <= in_action;
			key_q      <= in_key;
			n_q        <= '0;
			has_free_q <= 1'b0;
			free_q     <= '0;
		end else if (cmd.advance) begin
			n_q        <= n_q + SLOT_BITS'(1);
			has_free_q <= hf_now;
			free_q     <= free_now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			present_q  <= match;
			rejected_q <= rej;
			live_q     <= count_nxt;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_present  = present_q;
	assign out_rejected = rejected_q;
	assign out_live     = live_q;

endmodule

`default_nettype wire
